// ----- rtl/dtbt_pkg.sv -----
package dtbt_pkg;

  localparam int DELTA_W     = 8;
  localparam int RESULT_W    = 32;
  localparam int CFG_W       = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] BLOCK_BITS_RST = 4'd8;

  typedef struct packed {
    logic [DELTA_W-1:0] diff_in;
    logic [DELTA_W-1:0] diff_out;
  } in_beat_t;

  typedef struct packed {
    logic [RESULT_W-1:0] entry_count;
    logic [DELTA_W-1:0]  best_delta_in;
    logic [DELTA_W-1:0]  best_delta_out;
    logic [RESULT_W-1:0] best_count;
  } out_beat_t;

endpackage

// ----- rtl/dtbt_ram.sv -----
module dtbt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/dtbt_fifo.sv -----
module dtbt_fifo #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         wdata,
  output logic                     full,
  input  logic                     pop,
  output logic [WIDTH-1:0]         rdata,
  output logic                     empty,
  output logic [$clog2(DEPTH):0]   level
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW:0]      count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign level   = count_r;
  assign rdata   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/dtbt_front.sv -----
module dtbt_front #(
  parameter int MAX_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dtbt_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                           in_push,
  input  dtbt_pkg::in_beat_t             in_data,
  output logic                           in_full,
  input  logic                           clearing,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [2*MAX_BITS-1:0]          q_idx,
  output logic [dtbt_pkg::DELTA_W-1:0]   q_dx,
  output logic [dtbt_pkg::DELTA_W-1:0]   q_dy
);

  localparam int IW = 2 * MAX_BITS;
  localparam int DW = dtbt_pkg::DELTA_W;

  logic [dtbt_pkg::CFG_W-1:0] block_bits_r;
  logic [dtbt_pkg::CFG_W-1:0] n_eff;
  logic [15:0]                mask_wide;
  logic [IW+DW-1:0]           idx_wide;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_bits_r <= dtbt_pkg::BLOCK_BITS_RST;
    end else if (cfg_wr_en) begin
      block_bits_r <= cfg_wr_data;
    end
  end

  // width zero counts as one, anything above the table width saturates
  always_comb begin
    if (block_bits_r == '0) begin
      n_eff = dtbt_pkg::CFG_W'(1);
    end else if (block_bits_r > dtbt_pkg::CFG_W'(MAX_BITS)) begin
      n_eff = dtbt_pkg::CFG_W'(MAX_BITS);
    end else begin
      n_eff = block_bits_r;
    end
  end

  assign mask_wide = (16'd1 << n_eff) - 16'd1;
  assign q_dx      = in_data.diff_in & mask_wide[DW-1:0];
  assign q_dy      = in_data.diff_out & mask_wide[DW-1:0];
  assign idx_wide  = ({{IW{1'b0}}, q_dx} << n_eff) | {{IW{1'b0}}, q_dy};
  assign q_idx     = idx_wide[IW-1:0];

  assign in_full = q_full || clearing;
  assign q_push  = in_push && !in_full;

endmodule

// ----- rtl/dtbt_back.sv -----
module dtbt_back #(
  parameter int MAX_BITS   = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         clearing,
  input  logic                         q_empty,
  input  logic [2*MAX_BITS-1:0]        q_idx,
  input  logic [dtbt_pkg::DELTA_W-1:0] q_dx,
  input  logic [dtbt_pkg::DELTA_W-1:0] q_dy,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output dtbt_pkg::out_beat_t          out_data
);

  localparam int IW    = 2 * MAX_BITS;
  localparam int DW    = dtbt_pkg::DELTA_W;
  localparam int RW    = dtbt_pkg::RESULT_W;
  localparam int OD    = dtbt_pkg::QUEUE_DEPTH;
  localparam int LW    = $clog2(OD) + 1;
  localparam int DEPTH = 1 << IW;

  logic                  clr_busy_r;
  logic [IW-1:0]         clr_addr_r;

  logic                  s1_valid_r;
  logic [IW-1:0]         s1_idx_r;
  logic [DW-1:0]         s1_dx_r;
  logic [DW-1:0]         s1_dy_r;

  logic                  fwd_valid_r;
  logic [IW-1:0]         fwd_idx_r;
  logic [COUNT_BITS-1:0] fwd_cnt_r;

  logic [COUNT_BITS-1:0] top_cnt_r;
  logic [DW-1:0]         top_in_r;
  logic [DW-1:0]         top_out_r;
  logic [COUNT_BITS-1:0] top_cnt_nxt;
  logic [DW-1:0]         top_in_nxt;
  logic [DW-1:0]         top_out_nxt;

  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] old_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [LW-1:0]         out_level;
  logic                  out_full;
  logic [63:0]           entry_ext;
  logic [63:0]           best_ext;
  dtbt_pkg::out_beat_t   res_beat;

  assign clearing = clr_busy_r;

  // issue only with room left in the result queue for the beat in flight
  assign q_pop = !q_empty && !clr_busy_r &&
                 ((LW+1)'(out_level) + (LW+1)'(s1_valid_r) < (LW+1)'(OD));

  dtbt_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_counts (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(q_idx),
    .rd_data(rd_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {IW{1'b1}}) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // previous cycle's write is not yet visible at the ram read port
  assign old_cnt = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_cnt_r : rd_cnt;
  assign new_cnt = (old_cnt == {COUNT_BITS{1'b1}}) ? old_cnt : old_cnt + 1'b1;

  assign wr_en   = clr_busy_r || s1_valid_r;
  assign wr_addr = clr_busy_r ? clr_addr_r : s1_idx_r;
  assign wr_data = clr_busy_r ? '0 : new_cnt;

  always_comb begin
    top_cnt_nxt = top_cnt_r;
    top_in_nxt  = top_in_r;
    top_out_nxt = top_out_r;
    if (s1_valid_r && (s1_dx_r != '0)) begin
      priority if ((s1_dx_r == top_in_r) && (s1_dy_r == top_out_r) && (top_cnt_r != '0)) begin
        top_cnt_nxt = new_cnt;
      end else if ((new_cnt > top_cnt_r) ||
                   ((new_cnt == top_cnt_r) &&
                    ({s1_dx_r, s1_dy_r} < {top_in_r, top_out_r}))) begin
        top_cnt_nxt = new_cnt;
        top_in_nxt  = s1_dx_r;
        top_out_nxt = s1_dy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      top_cnt_r   <= '0;
      top_in_r    <= '0;
      top_out_r   <= '0;
    end else begin
      s1_valid_r  <= q_pop;
      fwd_valid_r <= s1_valid_r;
      top_cnt_r   <= top_cnt_nxt;
      top_in_r    <= top_in_nxt;
      top_out_r   <= top_out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= q_idx;
    s1_dx_r   <= q_dx;
    s1_dy_r   <= q_dy;
    fwd_idx_r <= s1_idx_r;
    fwd_cnt_r <= new_cnt;
  end

  assign entry_ext = 64'(new_cnt);
  assign best_ext  = 64'(top_cnt_nxt);

  always_comb begin
    res_beat.entry_count    = entry_ext[RW-1:0];
    res_beat.best_delta_in  = top_in_nxt;
    res_beat.best_delta_out = top_out_nxt;
    res_beat.best_count     = best_ext[RW-1:0];
  end

  dtbt_fifo #(
    .WIDTH($bits(dtbt_pkg::out_beat_t)),
    .DEPTH(OD)
  ) u_out_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (s1_valid_r),
    .wdata(res_beat),
    .full (out_full),
    .pop  (out_pop),
    .rdata(out_data),
    .empty(out_empty),
    .level(out_level)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

// ----- rtl/difference_table_best_tracker.sv -----
// throughput: one beat per cycle in both directions while not clearing and with
//   result queue room, limited by the count ram's single read and write port
//   with write-to-read forwarding; beats pass mid queue, s1 stage, result queue
// reset: rst_n synchronous; block width returns to 8, best entry to zero, and a
//   clearing pass over all 2^(2*MAX_BITS) entries (65536 by default) zeroes the table
//   while in_full stays high; configuration writes are taken throughout
module difference_table_best_tracker #(
  parameter int MAX_BITS   = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [dtbt_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                       in_push,
  input  dtbt_pkg::in_beat_t         in_data,
  output logic                       in_full,
  input  logic                       out_pop,
  output logic                       out_empty,
  output dtbt_pkg::out_beat_t        out_data
);

  localparam int IW = 2 * MAX_BITS;
  localparam int DW = dtbt_pkg::DELTA_W;
  localparam int QW = IW + 2 * DW;

  logic          clearing;
  logic          fq_push;
  logic          fq_full;
  logic [IW-1:0] fq_idx;
  logic [DW-1:0] fq_dx;
  logic [DW-1:0] fq_dy;
  logic          bq_empty;
  logic          bq_pop;
  logic [QW-1:0] bq_data;
  logic [$clog2(dtbt_pkg::QUEUE_DEPTH):0] mq_level;

  dtbt_front #(
    .MAX_BITS(MAX_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_push    (in_push),
    .in_data    (in_data),
    .in_full    (in_full),
    .clearing   (clearing),
    .q_full     (fq_full),
    .q_push     (fq_push),
    .q_idx      (fq_idx),
    .q_dx       (fq_dx),
    .q_dy       (fq_dy)
  );

  dtbt_fifo #(
    .WIDTH(QW),
    .DEPTH(dtbt_pkg::QUEUE_DEPTH)
  ) u_mid_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (fq_push),
    .wdata({fq_idx, fq_dx, fq_dy}),
    .full (fq_full),
    .pop  (bq_pop),
    .rdata(bq_data),
    .empty(bq_empty),
    .level(mq_level)
  );

  dtbt_back #(
    .MAX_BITS  (MAX_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .q_empty  (bq_empty),
    .q_idx    (bq_data[QW-1 -: IW]),
    .q_dx     (bq_data[2*DW-1 -: DW]),
    .q_dy     (bq_data[DW-1:0]),
    .q_pop    (bq_pop),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  logic unused_level;
  assign unused_level = ^mq_level;

endmodule
